@@ hw/rtl/bfshd_pkg.sv @@
package bfshd_pkg;

    localparam int OPCODE_W = 2;
    localparam int NODE_W   = 6;
    localparam int COUNT_W  = 7;
    localparam int TOTAL_W  = 7;

    typedef logic [OPCODE_W-1:0] opcode_t;
    typedef logic [NODE_W-1:0]   node_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [TOTAL_W-1:0]  total_t;

    localparam opcode_t OP_CLEAR = 2'd0;
    localparam opcode_t OP_EDGE  = 2'd1;
    localparam opcode_t OP_QUERY = 2'd2;

    localparam count_t NODE_COUNT_RESET = 7'd64;

endpackage

@@ hw/rtl/bfshd_item_if.sv @@
interface bfshd_item_if import bfshd_pkg::*;;

    logic    valid;
    logic    ready;
    opcode_t opcode;
    node_t   node_a;
    node_t   node_b;

    modport source (output valid, output opcode, output node_a, output node_b, input ready);
    modport sink (input valid, input opcode, input node_a, input node_b, output ready);

endinterface

@@ hw/rtl/bfshd_result_if.sv @@
interface bfshd_result_if import bfshd_pkg::*;;

    logic   valid;
    logic   ready;
    total_t longest_total;
    logic   unreachable;

    modport source (output valid, output longest_total, output unreachable, input ready);
    modport sink (input valid, input longest_total, input unreachable, output ready);

endinterface

@@ hw/rtl/bfs_hop_distance_max_sum.sv @@
// Undirected graph hop-distance engine. A clear item is done in the idle state, an edge
// item with both nodes in range is a read-modify-write of both adjacency rows, and a
// query runs two level-by-level searches followed by the result. Each search has a start
// state, a scan that reads the row of each frontier node and a level-end step per level.
// The query time is set by the single read port of the adjacency row memory, which is
// read one frontier node per cycle. The item channel is not ready while an item is being
// worked on; a finished result sits in an output register until taken, and a query whose
// result finds that register still full waits until it is taken. The adjacency matrix is
// cleared at once through per-row valid bits, so there is no clearing pass after reset.
module bfs_hop_distance_max_sum import bfshd_pkg::*;
#(
    parameter int MAX_NODES = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  node_count_we,
    input  count_t                node_count_wdata,
    bfshd_item_if.sink            item,
    bfshd_result_if.source        result
);

    localparam int AW = $clog2(MAX_NODES);
    localparam count_t MAX_COUNT = COUNT_W'(MAX_NODES);

    typedef logic [MAX_NODES-1:0] row_t;
    typedef logic [AW-1:0]        idx_t;

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_EDGE_RD_A = 9'b000000010,
        ST_EDGE_WR_A = 9'b000000100,
        ST_EDGE_RD_B = 9'b000001000,
        ST_EDGE_WR_B = 9'b000010000,
        ST_INIT      = 9'b000100000,
        ST_SCAN      = 9'b001000000,
        ST_LEVEL_END = 9'b010000000,
        ST_RESULT    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    count_t node_count_reg;
    count_t n_reg, n_next;
    node_t  a_reg, a_next;
    node_t  b_reg, b_next;
    row_t   row_valid_reg, row_valid_next;
    row_t   used_reg, used_next;
    row_t   visited_reg, visited_next;
    row_t   pending_reg, pending_next;
    row_t   acc_reg, acc_next;
    count_t level_reg, level_next;
    total_t best_reg, best_next;
    logic   pass_reg, pass_next;
    logic   inflight_reg, inflight_next;
    logic   reach_a_ok_reg, reach_a_ok_next;
    logic   result_valid_reg, result_valid_next;
    total_t total_reg, total_next;
    logic   unreach_reg, unreach_next;

    // adjacency rows and hop distances
    row_t   adj_mem [MAX_NODES];
    count_t hop_mem [MAX_NODES];
    row_t   adj_rd_reg;
    logic   row_ok_reg;
    count_t hop_rd_reg;

    logic   adj_re, adj_we, hop_we, hop_re;
    idx_t   adj_ra, adj_wa;
    row_t   adj_wd;

    row_t   iso;
    idx_t   v_idx;
    row_t   row_masked;
    row_t   next_front;
    node_t  start;
    count_t n_clamp;
    logic [TOTAL_W:0] sum;
    logic   miss;

    assign item.ready           = (state_reg == ST_IDLE);
    assign result.valid         = result_valid_reg;
    assign result.longest_total = total_reg;
    assign result.unreachable   = unreach_reg;

    // lowest pending frontier node
    always_comb
    begin
        iso   = pending_reg & (~pending_reg + row_t'(1));
        v_idx = '0;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            if (iso[i])
            begin
                v_idx = v_idx | idx_t'(i);
            end
        end
    end

    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_clamp = COUNT_W'(1);
        end
        else if (node_count_reg > MAX_COUNT)
        begin
            n_clamp = MAX_COUNT;
        end
        else
        begin
            n_clamp = node_count_reg;
        end
    end

    assign row_masked = adj_rd_reg & {MAX_NODES{row_ok_reg}};
    assign next_front = acc_reg & used_reg & ~visited_reg;
    assign start      = pass_reg ? b_reg : a_reg;
    assign sum        = {1'b0, hop_rd_reg} + {1'b0, level_reg};
    assign miss       = !reach_a_ok_reg || (visited_reg != used_reg);

    always_comb
    begin
        state_next        = state_reg;
        n_next            = n_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        row_valid_next    = row_valid_reg;
        used_next         = used_reg;
        visited_next      = visited_reg;
        pending_next      = pending_reg;
        acc_next          = acc_reg;
        level_next        = level_reg;
        best_next         = best_reg;
        pass_next         = pass_reg;
        inflight_next     = inflight_reg;
        reach_a_ok_next   = reach_a_ok_reg;
        result_valid_next = result_valid_reg && !result.ready;
        total_next        = total_reg;
        unreach_next      = unreach_reg;
        adj_re            = 1'b0;
        adj_ra            = v_idx;
        adj_we            = 1'b0;
        adj_wa            = a_reg[AW-1:0];
        adj_wd            = row_masked | (row_t'(1) << b_reg[AW-1:0]);
        hop_we            = 1'b0;
        hop_re            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    a_next = item.node_a;
                    b_next = item.node_b;
                    case (item.opcode)
                        OP_CLEAR:
                        begin
                            row_valid_next = '0;
                        end
                        OP_EDGE:
                        begin
                            if (({1'b0, item.node_a} < MAX_COUNT)
                                && ({1'b0, item.node_b} < MAX_COUNT))
                            begin
                                state_next = ST_EDGE_RD_A;
                            end
                        end
                        OP_QUERY:
                        begin
                            n_next    = n_clamp;
                            pass_next = 1'b0;
                            best_next = '0;
                            for (int i = 0; i < MAX_NODES; i++)
                            begin
                                used_next[i] = (COUNT_W'(i) < n_clamp);
                            end
                            state_next = ST_INIT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_EDGE_RD_A:
            begin
                adj_re     = 1'b1;
                adj_ra     = a_reg[AW-1:0];
                state_next = ST_EDGE_WR_A;
            end
            ST_EDGE_WR_A:
            begin
                adj_we                        = 1'b1;
                row_valid_next[a_reg[AW-1:0]] = 1'b1;
                state_next                    = ST_EDGE_RD_B;
            end
            ST_EDGE_RD_B:
            begin
                adj_re     = 1'b1;
                adj_ra     = b_reg[AW-1:0];
                state_next = ST_EDGE_WR_B;
            end
            ST_EDGE_WR_B:
            begin
                adj_we                        = 1'b1;
                adj_wa                        = b_reg[AW-1:0];
                adj_wd                        = row_masked | (row_t'(1) << a_reg[AW-1:0]);
                row_valid_next[b_reg[AW-1:0]] = 1'b1;
                state_next                    = ST_IDLE;
            end
            ST_INIT:
            begin
                if ({1'b0, start} < n_reg)
                begin
                    visited_next = row_t'(1) << start[AW-1:0];
                end
                else
                begin
                    visited_next = '0;
                end
                pending_next  = visited_next;
                acc_next      = '0;
                level_next    = '0;
                inflight_next = 1'b0;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                // fold the row fetched last cycle
                if (inflight_reg)
                begin
                    acc_next = acc_reg | row_masked;
                    if (pass_reg && (sum > {1'b0, best_reg}))
                    begin
                        best_next = sum[TOTAL_W-1:0];
                    end
                end
                if (pending_reg != '0)
                begin
                    adj_re        = 1'b1;
                    hop_we        = !pass_reg;
                    hop_re        = pass_reg;
                    pending_next  = pending_reg & ~iso;
                    inflight_next = 1'b1;
                end
                else
                begin
                    inflight_next = 1'b0;
                    if (!inflight_reg)
                    begin
                        state_next = ST_LEVEL_END;
                    end
                end
            end
            ST_LEVEL_END:
            begin
                visited_next = visited_reg | next_front;
                pending_next = next_front;
                acc_next     = '0;
                level_next   = level_reg + COUNT_W'(1);
                if (next_front != '0)
                begin
                    state_next = ST_SCAN;
                end
                else if (!pass_reg)
                begin
                    reach_a_ok_next = (visited_reg == used_reg);
                    pass_next       = 1'b1;
                    state_next      = ST_INIT;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!result_valid_reg || result.ready)
                begin
                    result_valid_next = 1'b1;
                    total_next        = miss ? '0 : best_reg;
                    unreach_next      = miss;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            node_count_reg   <= NODE_COUNT_RESET;
            row_valid_reg    <= '0;
            pass_reg         <= 1'b0;
            inflight_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            visited_reg      <= '0;
            pending_reg      <= '0;
            used_reg         <= '0;
            level_reg        <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            row_valid_reg    <= row_valid_next;
            pass_reg         <= pass_next;
            inflight_reg     <= inflight_next;
            result_valid_reg <= result_valid_next;
            visited_reg      <= visited_next;
            pending_reg      <= pending_next;
            used_reg         <= used_next;
            level_reg        <= level_next;
            if (node_count_we)
            begin
                node_count_reg <= node_count_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        acc_reg        <= acc_next;
        best_reg       <= best_next;
        reach_a_ok_reg <= reach_a_ok_next;
        total_reg      <= total_next;
        unreach_reg    <= unreach_next;
    end

    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_mem[adj_wa] <= adj_wd;
        end
        if (adj_re)
        begin
            adj_rd_reg <= adj_mem[adj_ra];
            row_ok_reg <= row_valid_reg[adj_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (hop_we)
        begin
            hop_mem[v_idx] <= level_reg;
        end
        if (hop_re)
        begin
            hop_rd_reg <= hop_mem[v_idx];
        end
    end

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_pending_visited: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg & ~visited_reg) == '0)
        else $error("frontier node not marked visited");

    a_visited_used: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_LEVEL_END) |-> (visited_reg & ~used_reg) == '0)
        else $error("search reached a node not in use");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && item.opcode == OP_QUERY) |=> !item.ready)
        else $error("item taken during query");

    a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.unreachable) |-> result.longest_total == '0)
        else $error("unreachable result carries nonzero total");
`endif

endmodule
